// ----- hw/rtl/kelst_pkg.sv -----
// Package for the keyed expiring light slot table: types, codes, sizes.
// No dependencies.
package kelst_pkg;
	localparam int SLOTS_DEF = 32;
	localparam int MAX_RESULTS = 32;

	typedef enum logic [1:0] {
		KIND_ADD_OK   = 2'd0,
		KIND_ADD_REJ  = 2'd1,
		KIND_ENTRY    = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [15:0]  key;
		logic [31:0]  die;
		logic [23:0]  radius;
		logic [15:0]  decay;
		logic [47:0]  origin;
		logic [23:0]  color;
	} slot_t;

	// Command broadcast to the cells while the row rotates.
	typedef struct packed {
		logic        rot;     // shift the row by one cell
		logic        age;     // age the slot leaving the head
		logic        wr;      // overwrite the slot leaving the head
		logic [31:0] now;
		logic [15:0] ftime;
		slot_t       wdata;
	} cell_ctl_t;
endpackage

// ----- hw/rtl/kelst_cell.sv -----
// One slot cell of the rotating row; the head cell applies aging or a write.
// Depends on kelst_pkg.
module kelst_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  kelst_pkg::cell_ctl_t ctl,
	input  logic               head,
	input  kelst_pkg::slot_t   din,
	output kelst_pkg::slot_t   dout
);
	import kelst_pkg::*;

	slot_t       slot_q;
	slot_t       nxt;
	logic [31:0] loss;

	assign dout = slot_q;
	assign loss = 32'(ctl.ftime) * 32'(din.decay);

	always_comb begin
		nxt = din;
		if (head && ctl.wr) begin
			nxt = ctl.wdata;
		end else if (head && ctl.age && din.radius != '0) begin
			if (din.die < ctl.now) begin
				nxt.radius = '0;
			end else if (loss >= 32'(din.radius)) begin
				nxt.radius = '0;
			end else begin
				nxt.radius = din.radius - loss[23:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctl.rot) begin
			slot_q <= nxt;
		end
	end
endmodule

// ----- hw/rtl/keyed_expiring_light_slot_table_unit.sv -----
// Top level of the keyed expiring light slot table: rotating row of cells
// and the sequencer. Depends on kelst_pkg and kelst_cell.
//
// channel  dir  fields
// s_axis   in   tuser: req_type; tdata: now_time, frame_time, light_key,
//               light_radius, decay_rate, lifetime, pos_x, pos_y, pos_z, color_rgb
// m_axis   out  tdata: slot_index, out_key, out_x, out_y, out_z, out_color,
//               out_radius; tuser: kind; tlast: last
//
// An accepted add or a frame item runs a first lap over the slots (pick or
// age), a second lap (write or list), a step to post the last result and an
// idle step before the next accept. A rejected add goes straight to the
// result step. While a listed item waits for m_axis_tready
// the row stops rotating, and the result cycle waits for a free output.
// Reset clears every slot. One item is worked on at a time.
module keyed_expiring_light_slot_table_unit #(
	parameter int SLOTS = kelst_pkg::SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// req_type
	input  logic         s_axis_tuser,
	// now_time[31:0], frame_time[47:32], light_key[63:48],
	// light_radius[87:64], decay_rate[103:88], lifetime[135:104],
	// pos_x[151:136], pos_y[167:152], pos_z[183:168], color_rgb[207:184]
	input  logic [207:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// slot_index[5:0], out_key[21:6], out_x[37:22], out_y[53:38],
	// out_z[69:54], out_color[93:70], out_radius[117:94]
	output logic [119:0] m_axis_tdata,
	// kind[1:0]
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tlast
);
	import kelst_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	// latched item
	logic        req_q;
	logic [31:0] now_q;
	logic [15:0] ftime_q;
	slot_t       new_q;
	logic [CW-1:0] cnt_q;      // position of the head slot in the lap
	logic [IW-1:0] pick_q;
	logic        key_hit_q, die_hit_q;
	logic [5:0]  listed_q;
	state_t      state_q, state_d;

	// output register
	logic        ovalid_q;
	logic [1:0]  okind_q;
	logic [5:0]  oidx_q;
	slot_t       oslot_q;
	logic        olast_q;

	cell_ctl_t   ctl;
	slot_t       chain [SLOTS];
	slot_t       head_s;
	logic        fire_in, out_free;
	logic        lap_end;
	logic [IW-1:0] cnt_i;

	assign head_s   = chain[SLOTS-1];
	assign fire_in  = s_axis_tvalid && s_axis_tready;
	assign out_free = !ovalid_q || m_axis_tready;
	assign lap_end  = (cnt_q == CW'(SLOTS - 1));
	assign cnt_i    = cnt_q[IW-1:0];
	assign s_axis_tready = (state_q == ST_IDLE);

	// Cell i holds slot (SLOTS-1-i+cnt) mod SLOTS in a lap; the last cell is the head
	// and feeds cell 0, so a lap of SLOTS rotations returns the row home.
	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			kelst_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl),
				.head(g == 0),
				.din(chain[(g + SLOTS - 1) % SLOTS]),
				.dout(chain[g])
			);
		end
	endgenerate

	logic list_now;
	assign list_now = (state_q == ST_EMIT) && req_q && head_s.radius != '0
		&& (listed_q < 6'(MAX_RESULTS));

	always_comb begin
		ctl       = '0;
		ctl.now   = now_q;
		ctl.ftime = ftime_q;
		ctl.wdata = new_q;
		state_d   = state_q;
		case (state_q)
			ST_IDLE: ;
			ST_SCAN: begin
				ctl.rot = 1'b1;
				ctl.age = req_q;
				if (lap_end) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!list_now || out_free) begin
					ctl.rot = 1'b1;
					ctl.wr  = !req_q && (cnt_i == pick_q);
					if (lap_end) state_d = ST_DONE;
				end
			end
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_IDLE && fire_in) begin
			if (s_axis_tuser || s_axis_tdata[87:64] != '0) state_d = ST_SCAN;
			else state_d = ST_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			ovalid_q  <= 1'b0;
			okind_q   <= KIND_ADD_OK;
			oidx_q    <= '0;
			oslot_q   <= '0;
			olast_q   <= 1'b0;
			listed_q  <= '0;
			key_hit_q <= 1'b0;
			die_hit_q <= 1'b0;
			pick_q    <= '0;
			req_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			// every lap ends with the count back at zero
			if (ctl.rot) cnt_q <= lap_end ? '0 : cnt_q + 1'b1;
			if (state_q == ST_IDLE && fire_in) begin
				req_q     <= s_axis_tuser;
				listed_q  <= '0;
				key_hit_q <= 1'b0;
				die_hit_q <= 1'b0;
				pick_q    <= '0;
			end
			// slot pick during the first lap of an add
			if (state_q == ST_SCAN && !req_q) begin
				if (!key_hit_q && new_q.key != '0 && head_s.key == new_q.key) begin
					key_hit_q <= 1'b1;
					pick_q    <= cnt_i;
				end else if (!key_hit_q && !die_hit_q && head_s.die < now_q) begin
					die_hit_q <= 1'b1;
					pick_q    <= cnt_i;
				end
			end
			if (list_now && out_free) begin
				ovalid_q <= 1'b1;
				okind_q  <= KIND_ENTRY;
				oidx_q   <= 6'(cnt_i);
				oslot_q  <= head_s;
				olast_q  <= 1'b0;
				listed_q <= listed_q + 1'b1;
			end else if (state_q == ST_DONE && out_free) begin
				olast_q  <= 1'b1;
				if (!req_q) begin
					ovalid_q <= 1'b1;
					if (new_q.radius == '0) begin
						okind_q <= KIND_ADD_REJ;
						oidx_q  <= '0;
						oslot_q <= '0;
					end else begin
						okind_q <= KIND_ADD_OK;
						oidx_q  <= 6'(pick_q);
						oslot_q <= new_q;
					end
				end else if (listed_q == '0) begin
					ovalid_q <= 1'b1;
					okind_q  <= KIND_NONE;
					oidx_q   <= '0;
					oslot_q  <= '0;
				end else begin
					// final entry already went out with tlast
					ovalid_q <= 1'b0;
				end
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && fire_in) begin
			now_q        <= s_axis_tdata[31:0];
			ftime_q      <= s_axis_tdata[47:32];
			new_q.key    <= s_axis_tdata[63:48];
			new_q.radius <= s_axis_tdata[87:64];
			new_q.decay  <= s_axis_tdata[103:88];
			new_q.die    <= s_axis_tdata[31:0] + s_axis_tdata[135:104];
			new_q.origin <= s_axis_tdata[183:136];
			new_q.color  <= s_axis_tdata[207:184];
		end
	end

	// An entry is last when no lit slot follows it in the lap or the list is
	// full; computed from a lookahead over the row (independent compares).
	logic more_lit;
	always_comb begin
		more_lit = 1'b0;
		for (int i = 0; i < SLOTS - 1; i++) begin
			if (i < SLOTS - 1 - int'(cnt_q) && chain[SLOTS-2-i].radius != '0)
				more_lit = 1'b1;
		end
	end
	logic olast_ent;
	always_ff @(posedge clk) begin
		if (list_now && out_free)
			olast_ent <= !more_lit || (listed_q == 6'(MAX_RESULTS - 1));
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tuser  = okind_q;
	assign m_axis_tlast  = (okind_q == KIND_ENTRY) ? olast_ent : olast_q;
	assign m_axis_tdata  = {2'b00, oslot_q.radius, oslot_q.color, oslot_q.origin,
		oslot_q.key, oidx_q};
endmodule

// ----- hw/rtl/kelst_checker.sv -----
// Port-level checker for the light slot table, bound to the top level.
// Depends on kelst_pkg.
module kelst_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [119:0] m_axis_tdata,
	input logic [1:0]   m_axis_tuser,
	input logic         m_axis_tlast
);
	import kelst_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_ENTRY |-> m_axis_tlast)
		else $error("single result without last");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_ENTRY |-> !s_axis_tready)
		else $error("input taken while listing");
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_ADD_REJ || m_axis_tuser == KIND_NONE)
		|-> m_axis_tdata == '0)
		else $error("empty result carries data");
endmodule

bind keyed_expiring_light_slot_table_unit kelst_checker u_chk (.*);

// ----- bench/tb_keyed_expiring_light_slot_table_unit.sv -----
// Testbench for keyed_expiring_light_slot_table_unit: directed table then random adds
// and frames, checked against an in-bench light table predictor. Depends on kelst_pkg.
module tb_keyed_expiring_light_slot_table_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import kelst_pkg::*;

	localparam int NSLOT = 32;
	localparam int WATCHDOG = 20000;

	typedef struct {
		logic        req;
		logic [31:0] now;
		logic [15:0] ftime, key;
		logic [23:0] radius;
		logic [15:0] decay;
		logic [31:0] life;
		logic [15:0] x, y, z;
		logic [23:0] color;
	} light_req_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  idx;
		logic [15:0] key, x, y, z;
		logic [23:0] color, radius;
		logic        last;
	} light_out_t;

	logic clk = 0, arst_n = 0;
	logic s_axis_tvalid = 0, m_axis_tready = 0;
	logic s_axis_tuser = 0;
	logic [207:0] s_axis_tdata = '0;
	logic s_axis_tready, m_axis_tvalid, m_axis_tlast;
	logic [119:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	keyed_expiring_light_slot_table_unit #(.SLOTS(NSLOT)) dut (.*);

	initial forever #5 clk = ~clk;

	// predictor state
	logic [15:0] t_key[NSLOT];
	logic [31:0] t_die[NSLOT];
	logic [23:0] t_rad[NSLOT];
	logic [15:0] t_dec[NSLOT];
	logic [15:0] t_x[NSLOT], t_y[NSLOT], t_z[NSLOT];
	logic [23:0] t_col[NSLOT];

	light_out_t pending_lights[$];
	int mismatches = 0, results_seen = 0, quiet = 0;
	bit calm = 0;

	function automatic light_out_t slot_out(kind_t k, int i, logic l);
		light_out_t o;
		o.kind = k; o.idx = i[5:0]; o.key = t_key[i]; o.x = t_x[i]; o.y = t_y[i];
		o.z = t_z[i]; o.color = t_col[i]; o.radius = t_rad[i]; o.last = l;
		return o;
	endfunction

	function automatic light_out_t blank_out(kind_t k);
		light_out_t o;
		o = '{kind: k, idx: 0, key: 0, x: 0, y: 0, z: 0, color: 0, radius: 0, last: 1};
		return o;
	endfunction

	// apply one item to the table and queue what it should produce
	task automatic predict_lights(light_req_t r);
		int sel, n;
		logic [31:0] loss;
		bit found;
		if (!r.req) begin
			if (r.radius == 0) begin
				pending_lights.push_back(blank_out(KIND_ADD_REJ));
				return;
			end
			sel = 0; found = 0;
			if (r.key != 0)
				for (int i = 0; i < NSLOT; i++)
					if (!found && t_key[i] == r.key) begin sel = i; found = 1; end
			for (int i = 0; i < NSLOT; i++)
				if (!found && t_die[i] < r.now) begin sel = i; found = 1; end
			t_key[sel] = r.key; t_x[sel] = r.x; t_y[sel] = r.y; t_z[sel] = r.z;
			t_col[sel] = r.color; t_die[sel] = r.now + r.life;
			t_dec[sel] = r.decay; t_rad[sel] = r.radius;
			pending_lights.push_back(slot_out(KIND_ADD_OK, sel, 1));
			return;
		end
		for (int i = 0; i < NSLOT; i++) begin
			if (t_rad[i] == 0) continue;
			if (t_die[i] < r.now) begin t_rad[i] = 0; continue; end
			loss = 32'(r.ftime) * 32'(t_dec[i]);
			t_rad[i] = (loss >= 32'(t_rad[i])) ? 24'd0 : t_rad[i] - loss[23:0];
		end
		n = 0;
		for (int i = 0; i < NSLOT && n < MAX_RESULTS; i++)
			if (t_rad[i] != 0) begin
				pending_lights.push_back(slot_out(KIND_ENTRY, i, 0));
				n++;
			end
		if (n == 0) pending_lights.push_back(blank_out(KIND_NONE));
		else pending_lights[$].last = 1;
	endtask

	function automatic logic [207:0] pack_req(light_req_t r);
		return {r.color, r.z, r.y, r.x, r.life, r.decay, r.radius, r.key,
			r.ftime, r.now};
	endfunction

	function automatic light_req_t rand_req(bit frame);
		light_req_t r;
		r.req = frame;
		r.now = $urandom_range(3) == 0 ? $urandom : $urandom_range(5000);
		r.ftime = $urandom_range(7) == 0 ? 16'($urandom) : 16'($urandom_range(20));
		r.key = $urandom_range(2) == 0 ? 16'd0 :
			($urandom_range(4) == 0 ? 16'($urandom) : 16'($urandom_range(6)));
		r.radius = $urandom_range(9) == 0 ? 24'd0 : 24'($urandom);
		r.decay = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(300));
		r.life = $urandom_range(3) == 0 ? $urandom : $urandom_range(3000);
		r.x = 16'($urandom); r.y = 16'($urandom); r.z = 16'($urandom);
		r.color = 24'($urandom);
		return r;
	endfunction

	// checker on m_axis
	always @(posedge clk) begin
		light_out_t a, e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			a.idx = m_axis_tdata[5:0]; a.key = m_axis_tdata[21:6];
			a.x = m_axis_tdata[37:22]; a.y = m_axis_tdata[53:38];
			a.z = m_axis_tdata[69:54]; a.color = m_axis_tdata[93:70];
			a.radius = m_axis_tdata[117:94]; a.kind = kind_t'(m_axis_tuser);
			a.last = m_axis_tlast;
			results_seen++;
			if (pending_lights.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item kind=%0d idx=%0d", a.kind, a.idx);
			end else begin
				e = pending_lights.pop_front();
				if (a !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch exp k%0d i%0d key%h %h/%h/%h c%h r%h l%0d",
							" got k%0d i%0d key%h %h/%h/%h c%h r%h l%0d"},
							e.kind, e.idx, e.key, e.x, e.y, e.z, e.color, e.radius,
							e.last, a.kind, a.idx, a.key, a.x, a.y, a.z, a.color,
							a.radius, a.last);
				end
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		int b;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(3) == 0) begin
				b = $urandom_range(13, 1);
				m_axis_tready <= 0;
				repeat (b) @(posedge clk);
			end
			m_axis_tready <= 1;
		end
	end

	// watchdog on accepted items
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("watchdog expired");
			$display("end of test: mismatches");
			$finish;
		end
	end

	// returns at the edge that accepts the item
	task automatic send_light(light_req_t r);
		s_axis_tdata <= pack_req(r);
		s_axis_tuser <= r.req;
		s_axis_tvalid <= 1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_lights(r);
	endtask

	task automatic idle_gap();
		if (!calm && $urandom_range(3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(13, 1)) @(posedge clk);
		end
	endtask

	// stop sending until every expected result has come
	task automatic drain();
		s_axis_tvalid <= 0;
		do @(posedge clk); while (pending_lights.size() != 0);
	endtask

	light_req_t dir_rows[$];
	light_out_t dir_exp[$];
	bit dir_has[$];

	initial begin
		light_req_t r, base;
		light_out_t e;
		int frames = 0, adds = 0;
		for (int i = 0; i < NSLOT; i++) begin
			t_key[i] = 0; t_die[i] = 0; t_rad[i] = 0; t_dec[i] = 0;
			t_x[i] = 0; t_y[i] = 0; t_z[i] = 0; t_col[i] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table: frame on empty table, rejected add, extremes, key reuse,
		// expiry, saturation, die-time wrap
		base = '{req: 0, now: 0, ftime: 0, key: 0, radius: 0, decay: 0, life: 0,
			x: 0, y: 0, z: 0, color: 0};
		r = base; r.req = 1;
		dir_rows.push_back(r); dir_exp.push_back(blank_out(KIND_NONE)); dir_has.push_back(1);
		r = base; r.key = 16'hffff; r.x = 16'h7fff; r.color = 24'hffffff;
		dir_rows.push_back(r); dir_exp.push_back(blank_out(KIND_ADD_REJ)); dir_has.push_back(1);
		r = base; r.now = 32'd10; r.radius = 24'hffffff; r.key = 16'hffff;
		r.decay = 16'hffff; r.life = 32'hffffffff; r.x = 16'h8000; r.y = 16'h7fff;
		r.z = 16'hffff; r.color = 24'hffffff;
		e = '{kind: KIND_ADD_OK, idx: 0, key: 16'hffff, x: 16'h8000, y: 16'h7fff,
			z: 16'hffff, color: 24'hffffff, radius: 24'hffffff, last: 1};
		dir_rows.push_back(r); dir_exp.push_back(e); dir_has.push_back(1);
		r.radius = 24'd1; r.now = 32'd20; r.life = 32'd5;
		dir_rows.push_back(r); dir_has.push_back(0); dir_exp.push_back(e);
		r = base; r.now = 32'd30; r.radius = 24'h000100; r.key = 16'd7; r.decay = 16'd1;
		r.life = 32'd1000;
		dir_rows.push_back(r); dir_has.push_back(0); dir_exp.push_back(e);
		r = base; r.req = 1; r.now = 32'd30; r.ftime = 16'd3;
		dir_rows.push_back(r); dir_has.push_back(0); dir_exp.push_back(e);
		r.ftime = 16'hffff; r.now = 32'd40;
		dir_rows.push_back(r); dir_has.push_back(0); dir_exp.push_back(e);
		r = base; r.now = 32'hffffffff; r.radius = 24'd5; r.key = 16'd7;
		r.life = 32'd2; r.decay = 16'd0;
		dir_rows.push_back(r); dir_has.push_back(0); dir_exp.push_back(e);
		r = base; r.req = 1; r.now = 32'd2; r.ftime = 16'd0;
		dir_rows.push_back(r); dir_has.push_back(0); dir_exp.push_back(e);
		r.now = 32'd0; r.ftime = 16'hffff;
		dir_rows.push_back(r); dir_has.push_back(0); dir_exp.push_back(e);

		foreach (dir_rows[k]) begin
			send_light(dir_rows[k]);
			if (dir_has[k]) pending_lights[$] = dir_exp[k];
			idle_gap();
		end

		// hold off until the table has drained
		drain();

		// random: bursts of adds with occasional frames; last stretch without idling
		for (int n = 0; n < 220; n++) begin
			if (n == 180) calm = 1;
			r = rand_req($urandom_range(4) == 0);
			if (r.req) frames++; else adds++;
			send_light(r);
			idle_gap();
			if (n == 90) drain();
		end
		drain();
		repeat (100) @(posedge clk);

		$display("covered %0d directed rows, %0d random adds, %0d random frames, %0d results",
			dir_rows.size(), adds, frames, results_seen);
		if (mismatches == 0 && pending_lights.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
